// ----- sv/mmad_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mmad_pkg;

    // fixed field widths of the stream words
    localparam int SMP_W = 12;              // sample, average and reported value
    localparam int CH_W  = 4;               // channel number
    localparam int DB_W  = 12;              // deadband register

    // input word: channel, sample
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;

    // output word: channel, average, reported, zero fill
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    // default sizing
    localparam int CHANNELS_DEF = 9;
    localparam int WINDOW_DEF   = 8;

    localparam logic [DB_W-1:0] DEADBAND_RST = DB_W'(8);

    // op codes carried in tuser
    localparam logic OP_PRIME  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

endpackage

`default_nettype wire

// ----- sv/multichannel_moving_average_deadband_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Multichannel boxcar moving average with deadband. Each input word carries a
// channel number and a sample; tuser selects prime (0) or normal update (1). An
// update replaces the oldest sample in that channel's ring, keeps the running
// sum, and gives the truncated average; the reported value follows the average
// only when it moves by at least the deadband, and tuser of the result flags
// that. A prime fills the channel's ring with the sample and sets the reported
// value to it. A channel number at or above CHANNELS leaves all state alone and
// gives one result with average, reported and changed at zero. One item is in
// work at a time: no new word is taken until the last item's result is in the
// output register. An update reads the ring and channel memories with the sum
// update, then does the reciprocal multiply, then the deadband compare and
// write back. A prime fills the ring one slot a cycle, since the ring memory
// has a single write port. A finished result sits in the output register, and
// the next item is accepted while it waits; a later result that finds the
// register still full holds the block until the register drains. The deadband
// register is to be written through the cfg channel only while the block is
// idle; the block itself does not enforce this.
module multichannel_moving_average_deadband_top #(
    parameter int CHANNELS = mmad_pkg::CHANNELS_DEF,   // 1 .. 16
    parameter int WINDOW   = mmad_pkg::WINDOW_DEF      // 1 .. 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    // input stream
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [mmad_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // channel, sample
    input  wire logic [mmad_pkg::S_TUSER_W-1:0] i_s_axis_tuser,  // op

    // result stream
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic      [mmad_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // out_channel, average, reported, zeros
    output logic      [mmad_pkg::M_TUSER_W-1:0] o_m_axis_tuser,  // changed

    // deadband register write
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mmad_pkg::DB_W-1:0]      i_cfg_data
);
    import mmad_pkg::*;

    localparam int LOG_W  = $clog2(WINDOW);
    localparam int SUM_W  = SMP_W + LOG_W;                       // holds WINDOW full-scale samples
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CHI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RING_D = CHANNELS * WINDOW;
    localparam int RI_W   = (RING_D > 1) ? $clog2(RING_D) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SUM   = 5'b00010,
        S_DIV   = 5'b00100,
        S_PRIME = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    // per-channel word of the channel memory
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SMP_W-1:0] rep;
    } t_chan;

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [DB_W-1:0]    r_deadband;

    // item in work
    logic               r_op;
    logic [CH_W-1:0]    r_ch;
    logic [SMP_W-1:0]   r_smp;
    logic               r_bad;          // channel out of range
    logic [RI_W-1:0]    r_ring_idx;     // slot being replaced
    logic [POS_W-1:0]   r_cnt;          // prime fill counter
    logic [SUM_W-1:0]   r_sum;

    // per-channel ring position and reset-zero valid bits
    logic [POS_W-1:0]   r_pos [CHANNELS];
    logic [RING_D-1:0]  r_ring_vld;
    logic [CHANNELS-1:0] r_chan_vld;

    // memories and their registered read data
    logic [SMP_W-1:0]   ring_mem [RING_D];
    t_chan              chan_mem [CHANNELS];
    logic [SMP_W-1:0]   r_ring_q;
    t_chan              r_chan_q;

    // output register
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;
    logic [M_TUSER_W-1:0]   r_out_user;

    // ---------------------------------------------------------------------
    // input word decode
    // ---------------------------------------------------------------------
    logic               s_accept;
    logic [CH_W-1:0]    in_ch;
    logic [SMP_W-1:0]   in_smp;
    logic               in_bad;
    logic [CHI_W-1:0]   in_ci;
    logic [RI_W-1:0]    in_ring_idx;

    assign in_ch  = i_s_axis_tdata[CH_W-1:0];
    assign in_smp = i_s_axis_tdata[CH_W +: SMP_W];
    assign in_bad = !((CH_W+1)'(in_ch) < (CH_W+1)'(CHANNELS));
    assign in_ci  = in_bad ? '0 : CHI_W'(in_ch);
    assign in_ring_idx = RI_W'(int'(in_ci) * WINDOW + int'(r_pos[in_ci]));

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // datapath of the item in work
    // ---------------------------------------------------------------------
    logic [CHI_W-1:0]   ci;
    logic [SMP_W-1:0]   old_smp;
    logic [SUM_W-1:0]   old_sum;
    logic [SMP_W-1:0]   old_rep;
    logic [SMP_W-1:0]   avg_q;
    logic [SMP_W-1:0]   diff;
    logic               out_free;
    logic [RI_W-1:0]    prime_idx;

    assign ci       = r_bad ? '0 : CHI_W'(r_ch);
    assign old_smp  = r_ring_vld[r_ring_idx] ? r_ring_q : '0;
    assign old_sum  = r_chan_vld[ci] ? r_chan_q.sum : '0;
    assign old_rep  = r_chan_vld[ci] ? r_chan_q.rep : '0;
    assign diff     = (avg_q >= old_rep) ? (avg_q - old_rep) : (old_rep - avg_q);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign prime_idx = RI_W'(int'(ci) * WINDOW + int'(r_cnt));

    mmad_avg #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_avg (
        .i_clk  (i_clk),
        .i_sum  (r_sum),
        .o_avg  (avg_q)
    );

    // memory write ports and final result
    logic               ring_we;
    logic [RI_W-1:0]    ring_waddr;
    logic               chan_we;
    t_chan              chan_wdata;
    logic               fin_go;
    logic [SMP_W-1:0]   res_avg;
    logic [SMP_W-1:0]   res_rep;
    logic               res_chg;

    always_comb begin
        n_state    = r_state;
        ring_we    = 1'b0;
        ring_waddr = r_ring_idx;
        chan_we    = 1'b0;
        chan_wdata = '{sum: r_sum, rep: old_rep};
        fin_go     = 1'b0;
        res_avg    = '0;
        res_rep    = '0;
        res_chg    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (in_bad) begin
                        n_state = S_FIN;
                    end else if (i_s_axis_tuser[0] == OP_PRIME) begin
                        n_state = S_PRIME;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                // replace the oldest slot
                ring_we = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_FIN;
            end
            S_PRIME: begin
                ring_we    = 1'b1;
                ring_waddr = prime_idx;
                if (r_cnt == POS_W'(WINDOW - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    fin_go  = 1'b1;
                    n_state = S_IDLE;
                    if (r_bad) begin
                        res_avg = '0;
                        res_rep = '0;
                        res_chg = 1'b0;
                    end else if (r_op == OP_PRIME) begin
                        res_avg    = r_smp;
                        res_rep    = r_smp;
                        res_chg    = 1'b1;
                        chan_we    = 1'b1;
                        chan_wdata = '{sum: SUM_W'(32'(r_smp) * WINDOW), rep: r_smp};
                    end else begin
                        res_avg = avg_q;
                        // deadband test, a zero deadband always rewrites
                        if (diff >= r_deadband) begin
                            res_rep = avg_q;
                            res_chg = 1'b1;
                        end else begin
                            res_rep = old_rep;
                        end
                        chan_we    = 1'b1;
                        chan_wdata = '{sum: r_sum, rep: res_rep};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_deadband  <= DEADBAND_RST;
            r_ring_vld  <= '0;
            r_chan_vld  <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_pos[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_deadband <= i_cfg_data;
            end
            if (ring_we) begin
                r_ring_vld[ring_waddr] <= 1'b1;
            end
            if (chan_we) begin
                r_chan_vld[ci] <= 1'b1;
            end
            // prime fill counter
            if (s_accept) begin
                r_cnt <= '0;
            end else if (r_state == S_PRIME) begin
                r_cnt <= r_cnt + POS_W'(1);
            end
            // ring position advances on update only
            if (r_state == S_SUM) begin
                if (r_pos[ci] == POS_W'(WINDOW - 1)) begin
                    r_pos[ci] <= '0;
                end else begin
                    r_pos[ci] <= r_pos[ci] + POS_W'(1);
                end
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op       <= i_s_axis_tuser[0];
            r_ch       <= in_ch;
            r_smp      <= in_smp;
            r_bad      <= in_bad;
            r_ring_idx <= in_ring_idx;
        end
        if (r_state == S_SUM) begin
            // sum still includes the old slot, so this never wraps
            r_sum <= old_sum - SUM_W'(old_smp) + SUM_W'(r_smp);
        end
        if (fin_go) begin
            r_out_data <= {(M_TDATA_W - CH_W - 2*SMP_W)'(0), res_rep, res_avg, r_ch};
            r_out_user <= M_TUSER_W'(res_chg);
        end
    end

    // ring memory, one write and one read port
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= r_smp;
        end
        if (s_accept) begin
            r_ring_q <= ring_mem[in_ring_idx];
        end
    end

    // channel memory: running sum and reported value
    always_ff @(posedge i_clk) begin
        if (chan_we) begin
            chan_mem[ci] <= chan_wdata;
        end
        if (s_accept) begin
            r_chan_q <= chan_mem[in_ci];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

// ----- sv/mmad_avg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mmad_avg #(
    parameter int WINDOW = mmad_pkg::WINDOW_DEF,
    parameter int SUM_W  = mmad_pkg::SMP_W + $clog2(mmad_pkg::WINDOW_DEF)
) (
    input  wire logic                      i_clk,
    input  wire logic [SUM_W-1:0]          i_sum,
    output logic      [mmad_pkg::SMP_W-1:0] o_avg
);
    import mmad_pkg::*;

    // exact floor(sum / WINDOW) as sum * ceil(2^K / WINDOW) >> K
    localparam int LOG_W  = $clog2(WINDOW);
    localparam int K      = SUM_W + LOG_W;
    localparam int PROD_W = SUM_W + K + 1;
    localparam logic [K:0] RECIP = (K+1)'(((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(i_sum) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        o_avg <= prod[K +: SMP_W];
    end

endmodule

`default_nettype wire

// ----- tb/moving_average_checker.sv -----
`timescale 1ns / 1ps

// watches the input, result and deadband channels, keeps its own copy of the
// per-channel rings and sums, and compares every result word in order
module moving_average_checker #(
    parameter int CHANNELS = mmad_pkg::CHANNELS_DEF,
    parameter int WINDOW   = mmad_pkg::WINDOW_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    input  wire logic [mmad_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [mmad_pkg::S_TUSER_W-1:0] i_s_tuser,

    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [mmad_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  wire logic [mmad_pkg::M_TUSER_W-1:0] i_m_tuser,

    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [mmad_pkg::DB_W-1:0]      i_cfg_data,

    output int                                  o_pending,
    output int                                  o_errors,
    output int                                  o_results,
    output int                                  o_changes
);
    import mmad_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] average;
        logic [SMP_W-1:0] reported;
        logic             changed;
    } t_filt_result;

    logic [SMP_W-1:0] ring [CHANNELS][WINDOW];
    int unsigned      slot [CHANNELS];
    int unsigned      window_sum [CHANNELS];
    logic [SMP_W-1:0] last_rep [CHANNELS];
    logic [DB_W-1:0]  deadband;
    t_filt_result     expected_q[$];

    int mismatches = 0;
    int results    = 0;
    int changes    = 0;

    assign o_errors  = mismatches;
    assign o_results = results;
    assign o_changes = changes;

    // advances the channel state by one word and gives the result it causes
    function automatic t_filt_result filter_step(logic op, logic [CH_W-1:0] ch,
                                                 logic [SMP_W-1:0] smp);
        t_filt_result r;
        int unsigned  avg;
        int unsigned  diff;
        r = '0;
        r.channel = ch;
        // stray channel numbers touch no state
        if (ch >= CHANNELS)
            return r;
        if (op == OP_PRIME) begin
            for (int j = 0; j < WINDOW; j++)
                ring[ch][j] = smp;
            window_sum[ch] = int'(smp) * WINDOW;
            last_rep[ch]   = smp;
            r.average  = smp;
            r.reported = smp;
            r.changed  = 1'b1;
        end else begin
            window_sum[ch] = window_sum[ch] - ring[ch][slot[ch]] + smp;
            ring[ch][slot[ch]] = smp;
            slot[ch] = (slot[ch] + 1 == WINDOW) ? 0 : slot[ch] + 1;
            avg  = window_sum[ch] / WINDOW;
            diff = (avg >= last_rep[ch]) ? avg - last_rep[ch] : last_rep[ch] - avg;
            if (diff >= deadband) begin
                last_rep[ch] = SMP_W'(avg);
                r.changed    = 1'b1;
            end
            r.average  = SMP_W'(avg);
            r.reported = last_rep[ch];
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_filt_result want;
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int j = 0; j < WINDOW; j++)
                    ring[c][j] = '0;
                slot[c]       = 0;
                window_sum[c] = 0;
                last_rep[c]   = '0;
            end
            deadband = DEADBAND_RST;
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                results++;
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected, channel %0d",
                           i_m_tdata[CH_W-1:0]);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("out_channel", want.channel, i_m_tdata[CH_W-1:0]);
                    check_field("average", want.average, i_m_tdata[CH_W +: SMP_W]);
                    check_field("reported", want.reported,
                                i_m_tdata[CH_W+SMP_W +: SMP_W]);
                    check_field("fill", 0, i_m_tdata[M_TDATA_W-1:CH_W+2*SMP_W]);
                    check_field("changed", want.changed, i_m_tuser[0]);
                    if (want.changed)
                        changes++;
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_q.push_back(filter_step(i_s_tuser[0], i_s_tdata[CH_W-1:0],
                                                 i_s_tdata[CH_W +: SMP_W]));
            if (i_cfg_valid && i_cfg_ready)
                deadband = i_cfg_data;
        end
        o_pending <= expected_q.size();
    end

endmodule

// ----- tb/tb_multichannel_moving_average_deadband_top.sv -----
`timescale 1ns / 1ps

module tb_multichannel_moving_average_deadband_top;
    import mmad_pkg::*;

    localparam int CHANNELS     = CHANNELS_DEF;
    localparam int WINDOW       = WINDOW_DEF;
    localparam int RANDOM_WORDS = 1300;
    localparam int PHASES       = 10;
    localparam int SMP_MAX      = (1 << SMP_W) - 1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [S_TDATA_W-1:0] s_data  = '0;
    logic [S_TUSER_W-1:0] s_user  = '0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [M_TDATA_W-1:0] m_data;
    logic [M_TUSER_W-1:0] m_user;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [DB_W-1:0]      cfg_data  = '0;

    int pending, errors, results, changes;

    logic [DB_W-1:0]  cur_deadband = DEADBAND_RST;
    logic [SMP_W-1:0] level [16];
    bit               in_burst  = 1'b0;
    bit               out_burst = 1'b0;
    int               primes  = 0;
    int               updates = 0;
    int               strays  = 0;
    int               settings = 1;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    multichannel_moving_average_deadband_top #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    moving_average_checker #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .i_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .i_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .i_m_tdata   (m_data),
        .i_m_tuser   (m_user),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_results   (results),
        .o_changes   (changes)
    );

    // one sample word; valid stays up across back-to-back words
    task automatic send_word(logic op, logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {smp, ch};
        s_user  <= op;
        do @(posedge clk); while (!s_ready);
        if (ch >= CHANNELS)
            strays++;
        else if (op == OP_PRIME)
            primes++;
        else
            updates++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_deadband(logic [DB_W-1:0] value);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        cur_deadband = value;
        settings++;
    endtask

    // mostly updates hovering around a per-channel level so the deadband
    // compare sits near its threshold, with primes, strays and full-range noise
    task automatic send_random();
        logic             op;
        logic [CH_W-1:0]  ch;
        logic [SMP_W-1:0] smp;
        int               span;
        int               v;
        op = ($urandom_range(0, 19) == 0) ? OP_PRIME : OP_UPDATE;
        if ($urandom_range(0, 9) == 0)
            ch = CH_W'($urandom_range(CHANNELS, (1 << CH_W) - 1));
        else
            ch = CH_W'($urandom_range(0, CHANNELS - 1));
        case ($urandom_range(0, 9))
            0: smp = $urandom_range(0, 1) ? '1 : '0;
            1, 2, 3: smp = SMP_W'($urandom);
            default: begin
                span = (cur_deadband > 1000) ? SMP_MAX : 2 * cur_deadband + 3;
                v = int'(level[ch]) + int'($urandom_range(0, 2 * span)) - span;
                if (v < 0)
                    v = 0;
                else if (v > SMP_MAX)
                    v = SMP_MAX;
                smp = SMP_W'(v);
            end
        endcase
        if ($urandom_range(0, 49) == 0)
            level[ch] = SMP_W'($urandom);
        if ($urandom_range(0, 39) == 0)
            in_burst = !in_burst;
        send_word(op, ch, smp);
    endtask

    // result side: random stalls with stretches of steady acceptance
    initial begin
        int stall;
        forever begin
            stall = out_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!m_valid);
            if ($urandom_range(0, 39) == 0)
                out_burst = !out_burst;
        end
    end

    initial begin
        logic [DB_W-1:0] db;
        for (int c = 0; c < 16; c++)
            level[c] = SMP_W'($urandom);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset deadband: untouched channel, full-scale prime and step down,
        // top channel, stray channels with both ops, small move under deadband
        send_word(OP_UPDATE, 4'd0, '0);
        send_word(OP_PRIME,  4'd0, '1);
        send_word(OP_UPDATE, 4'd0, '0);
        send_word(OP_PRIME,  CH_W'(CHANNELS - 1), 12'hAAA);
        send_word(OP_UPDATE, CH_W'(CHANNELS - 1), 12'h555);
        send_word(OP_UPDATE, CH_W'(CHANNELS), '1);
        send_word(OP_PRIME,  '1, '1);
        send_word(OP_PRIME,  4'd3, '0);
        send_word(OP_UPDATE, 4'd3, 12'd7);
        send_word(OP_UPDATE, 4'd3, '1);
        send_word(OP_UPDATE, 4'd7, 12'h00F);
        wait_drained();

        // zero deadband flags even an unchanged average
        write_deadband('0);
        send_word(OP_PRIME,  4'd1, 12'd100);
        send_word(OP_UPDATE, 4'd1, 12'd100);
        send_word(OP_UPDATE, 4'd1, 12'd100);
        wait_drained();

        // full-scale deadband: only a zero to full-scale swing gets through
        write_deadband('1);
        send_word(OP_PRIME, 4'd2, '0);
        repeat (WINDOW) send_word(OP_UPDATE, 4'd2, '1);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: db = DB_W'($urandom_range(1, 40));
                1: db = '0;
                2: db = '1;
                3: db = DB_W'(1);
                4: db = DB_W'($urandom);
                5: db = DEADBAND_RST;
                6: db = DB_W'($urandom_range(2, 15));
                7: db = DB_W'($urandom_range(100, 600));
                default: db = DB_W'($urandom_range(0, 200));
            endcase
            write_deadband(db);
            repeat (RANDOM_WORDS / PHASES) send_random();
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("covered %0d primes, %0d updates and %0d stray-channel words over %0d deadband settings",
                 primes, updates, strays, settings);
        $display("%0d result words checked, %0d of them flagged as changed", results, changes);
        if (errors == 0)
            $display("[multichannel_moving_average_deadband_top] OK");
        else
            $display("[multichannel_moving_average_deadband_top] ERROR");
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("[multichannel_moving_average_deadband_top] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/mmad_pkg.sv
sv/mmad_avg.sv
sv/multichannel_moving_average_deadband_top.sv
tb/moving_average_checker.sv
tb/tb_multichannel_moving_average_deadband_top.sv
